>>> rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants
// Command codes, register indexes, phase codes and the item structs of the
// SPI flash read/program sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

   localparam int PAGE_BYTES  = 256;
   localparam int PAGE_ADDR_W = $clog2(PAGE_BYTES);

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_READ    = 2'd1,
      CMD_PROGRAM = 2'd2,
      CMD_LOAD    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_WREN_OP = 2'd0,
      CSR_PP_OP   = 2'd1,
      CSR_WRDI_OP = 2'd2,
      CSR_READ_OP = 2'd3
   } csr_index_type;

   localparam logic [7:0] WREN_OP_RESET = 8'h06;
   localparam logic [7:0] PP_OP_RESET   = 8'h02;
   localparam logic [7:0] WRDI_OP_RESET = 8'h04;
   localparam logic [7:0] READ_OP_RESET = 8'h03;

   typedef enum logic [10:0] {
      PH_IDLE  = 11'b000_0000_0001,
      PH_WREN  = 11'b000_0000_0010,
      PH_GAP1  = 11'b000_0000_0100,
      PH_PPCMD = 11'b000_0000_1000,
      PH_PADDR = 11'b000_0001_0000,
      PH_PDATA = 11'b000_0010_0000,
      PH_GAP2  = 11'b000_0100_0000,
      PH_WRDI  = 11'b000_1000_0000,
      PH_RCMD  = 11'b001_0000_0000,
      PH_RADDR = 11'b010_0000_0000,
      PH_RDATA = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [23:0] address;
      logic [8:0]  length;
      logic [7:0]  buffer_index;
      logic [7:0]  buffer_byte;
      logic        miso;
   } req_type;

   typedef struct packed {
      logic       chip_select_n;
      logic       serial_clock;
      logic       serial_out;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       rx_last;
      logic       busy_res;
      logic       status;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/sfs_ram.sv
// ----------------------------------------------------------------------------
// sfs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/sfs_engine.sv
// ----------------------------------------------------------------------------
// sfs_engine: serial sequencer state and per-item next-state logic
// Holds the opcode registers, phase, counters, shifters and pin levels, and
// the page buffer. Produces the result of the item presented on fire.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_engine import sfs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   input  wire logic       fire,
   input  wire req_type    req,
   output rsp_type         rsp
);

   logic [7:0] wren_op_ff, pp_op_ff, wrdi_op_ff, read_op_ff;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;
   logic [8:0]  byte_cnt_ff, byte_cnt_in;
   logic [8:0]  len_ff, len_in;
   logic [23:0] addr_ff, addr_in;
   logic [7:0]  shout_ff, shout_in;
   logic [7:0]  shin_ff, shin_in;
   logic        cs_ff, cs_in;
   logic        sck_ff, sck_in;
   logic        sdo_ff, sdo_in;

   logic                   buf_wr_en;
   logic [PAGE_ADDR_W-1:0] buf_rd_addr;
   logic [7:0]             buf_rd_data;

   logic       do_load, do_release;
   logic [7:0] load_val;
   phase_type  release_to;
   logic [7:0] shifted;
   logic [8:0] byte_next;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wren_op_ff <= WREN_OP_RESET;
         pp_op_ff   <= PP_OP_RESET;
         wrdi_op_ff <= WRDI_OP_RESET;
         read_op_ff <= READ_OP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_WREN_OP: wren_op_ff <= csr_wdata;
            CSR_PP_OP:   pp_op_ff   <= csr_wdata;
            CSR_WRDI_OP: wrdi_op_ff <= csr_wdata;
            CSR_READ_OP: read_op_ff <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // buffer is stable while busy; prefetch the slot the next data byte needs
   assign buf_rd_addr = (phase_ff == PH_PDATA) ?
                        PAGE_ADDR_W'(byte_cnt_ff + 9'd1) : '0;
   assign buf_wr_en   = fire && (req.cmd == CMD_LOAD) && (phase_ff == PH_IDLE) &&
                        (32'(req.buffer_index) < PAGE_BYTES);

   sfs_ram #(
      .WIDTH (8),
      .DEPTH (PAGE_BYTES)
   ) u_page_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (PAGE_ADDR_W'(req.buffer_index)),
      .wr_data (req.buffer_byte),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   assign shifted   = {shout_ff[6:0], 1'b0};
   assign byte_next = byte_cnt_ff + 9'd1;

   always_comb begin
      phase_in    = phase_ff;
      bit_cnt_in  = bit_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      len_in      = len_ff;
      addr_in     = addr_ff;
      shout_in    = shout_ff;
      shin_in     = shin_ff;
      cs_in       = cs_ff;
      sck_in      = sck_ff;
      sdo_in      = sdo_ff;
      do_load     = 1'b0;
      do_release  = 1'b0;
      load_val    = 8'h00;
      release_to  = PH_IDLE;
      rsp         = '0;

      case (req.cmd)
         CMD_TICK: begin
            if (phase_ff == PH_GAP1 || phase_ff == PH_GAP2) begin
               cs_in    = 1'b0;
               do_load  = 1'b1;
               load_val = (phase_ff == PH_GAP1) ? pp_op_ff : wrdi_op_ff;
               phase_in = (phase_ff == PH_GAP1) ? PH_PPCMD : PH_WRDI;
            end else if (phase_ff != PH_IDLE) begin
               bit_cnt_in = bit_cnt_ff + 4'd1;
               if (!bit_cnt_ff[0]) begin
                  // rising edge: sample on read data bytes
                  sck_in = 1'b1;
                  if (phase_ff == PH_RDATA) begin
                     shin_in = {shin_ff[6:0], req.miso};
                  end
               end else begin
                  sck_in   = 1'b0;
                  shout_in = shifted;
                  if (bit_cnt_ff != 4'd15) begin
                     sdo_in = (phase_ff == PH_RDATA) ? 1'b0 : shifted[7];
                  end else begin
                     case (phase_ff)
                        PH_WREN: begin
                           do_release = 1'b1;
                           release_to = PH_GAP1;
                        end
                        PH_PPCMD, PH_RCMD: begin
                           byte_cnt_in = '0;
                           do_load     = 1'b1;
                           load_val    = addr_ff[23:16];
                           phase_in    = (phase_ff == PH_PPCMD) ? PH_PADDR : PH_RADDR;
                        end
                        PH_PADDR, PH_RADDR: begin
                           if (byte_next < 9'd3) begin
                              byte_cnt_in = byte_next;
                              do_load     = 1'b1;
                              load_val    = (byte_next == 9'd1) ? addr_ff[15:8]
                                                                : addr_ff[7:0];
                           end else begin
                              byte_cnt_in = '0;
                              if (len_ff == '0) begin
                                 do_release = 1'b1;
                                 release_to = (phase_ff == PH_PADDR) ? PH_GAP2 : PH_IDLE;
                              end else if (phase_ff == PH_PADDR) begin
                                 do_load  = 1'b1;
                                 load_val = buf_rd_data;
                                 phase_in = PH_PDATA;
                              end else begin
                                 do_load  = 1'b1;
                                 shin_in  = '0;
                                 phase_in = PH_RDATA;
                              end
                           end
                        end
                        PH_PDATA: begin
                           byte_cnt_in = byte_next;
                           if (byte_next < len_ff) begin
                              do_load  = 1'b1;
                              load_val = buf_rd_data;
                           end else begin
                              do_release = 1'b1;
                              release_to = PH_GAP2;
                           end
                        end
                        PH_RDATA: begin
                           byte_cnt_in  = byte_next;
                           rsp.rx_byte  = shin_ff;
                           rsp.rx_valid = 1'b1;
                           shin_in      = '0;
                           if (byte_next >= len_ff) begin
                              rsp.rx_last = 1'b1;
                              do_release  = 1'b1;
                           end else begin
                              do_load = 1'b1;
                           end
                        end
                        default: begin
                           do_release = 1'b1;
                        end
                     endcase
                  end
               end
            end
         end
         CMD_LOAD: begin
            // buffer write handled by buf_wr_en
         end
         default: begin
            if (phase_ff != PH_IDLE || 32'(req.length) > PAGE_BYTES) begin
               rsp.status = 1'b1;
            end else begin
               addr_in     = req.address;
               len_in      = req.length;
               byte_cnt_in = '0;
               shin_in     = '0;
               cs_in       = 1'b0;
               sck_in      = 1'b0;
               do_load     = 1'b1;
               if (req.cmd == CMD_READ) begin
                  load_val = read_op_ff;
                  phase_in = PH_RCMD;
               end else begin
                  load_val = wren_op_ff;
                  phase_in = PH_WREN;
               end
            end
         end
      endcase

      if (do_load) begin
         shout_in   = load_val;
         bit_cnt_in = '0;
         sdo_in     = load_val[7];
      end
      if (do_release) begin
         cs_in      = 1'b1;
         sdo_in     = 1'b0;
         bit_cnt_in = '0;
         phase_in   = release_to;
      end

      rsp.chip_select_n = cs_in;
      rsp.serial_clock  = sck_in;
      rsp.serial_out    = sdo_in;
      rsp.busy_res      = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         bit_cnt_ff  <= '0;
         byte_cnt_ff <= '0;
         len_ff      <= '0;
         addr_ff     <= '0;
         shout_ff    <= '0;
         shin_ff     <= '0;
         cs_ff       <= 1'b1;
         sck_ff      <= 1'b0;
         sdo_ff      <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         bit_cnt_ff  <= bit_cnt_in;
         byte_cnt_ff <= byte_cnt_in;
         len_ff      <= len_in;
         addr_ff     <= addr_in;
         shout_ff    <= shout_in;
         shin_ff     <= shin_in;
         cs_ff       <= cs_in;
         sck_ff      <= sck_in;
         sdo_ff      <= sdo_in;
      end
   end

   // select only toggles with the clock low
   assert property (@(posedge clock) disable iff (reset) cs_ff |-> !sck_ff)
      else $error("serial clock high while deselected");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE || phase_ff == PH_GAP1 || phase_ff == PH_GAP2) |-> cs_ff)
      else $error("chip select low outside a segment");

   assert property (@(posedge clock) disable iff (reset)
      (fire && rsp.rx_valid) |-> (phase_ff == PH_RDATA && bit_cnt_ff == 4'd15))
      else $error("received byte outside a read data phase");

   assert property (@(posedge clock) disable iff (reset)
      (fire && rsp.rx_last) |=> (phase_ff == PH_IDLE && cs_ff))
      else $error("last byte did not end the read");

endmodule

`default_nettype wire

>>> rtl/spi_flash_read_program_sequencer_top.sv
// ----------------------------------------------------------------------------
// spi_flash_read_program_sequencer_top: tick-driven SPI NOR flash master
// Input register, sequencer engine with page buffer, and result register.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  req_     | in        | req_valid/req_stall  | cmd address length buffer_*
//           |           |                      | miso
//  rsp_     | out       | rsp_valid/rsp_stall  | pin levels, rx_*, busy, status
//  csr_     | in        | csr_wr_en            | csr_index csr_wdata
//
//  One item per cycle sustained while rsp_stall stays low; an item passes the
//  input register, then the result register, before its result is presented.
//  Throughput is set by the combinational next-state logic of the engine; the
//  page buffer read is prefetched, so it adds no wait.
//  Reset is synchronous and active high; the page buffer is not cleared.
//  A stalled result holds the result register and, once the input register is
//  full, stalls the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_flash_read_program_sequencer_top import sfs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [23:0] req_address,
   input  wire logic [8:0]  req_length,
   input  wire logic [7:0]  req_buffer_index,
   input  wire logic [7:0]  req_buffer_byte,
   input  wire logic        req_miso,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_chip_select_n,
   output logic             rsp_serial_clock,
   output logic             rsp_serial_out,
   output logic [7:0]       rsp_rx_byte,
   output logic             rsp_rx_valid,
   output logic             rsp_rx_last,
   output logic             rsp_busy_res,
   output logic             rsp_status,

   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type eng_rsp;
   logic    out_stall;
   logic    fire;

   assign out_stall   = out_valid_ff && rsp_stall;
   assign req_stall   = in_valid_ff && out_stall;
   assign fire        = in_valid_ff && !out_stall;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = out_stall ? out_valid_ff : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= '{cmd:          cmd_type'(req_cmd),
                         address:      req_address,
                         length:       req_length,
                         buffer_index: req_buffer_index,
                         buffer_byte:  req_buffer_byte,
                         miso:         req_miso};
      end
      if (fire) begin
         out_data_ff <= eng_rsp;
      end
   end

   sfs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .req       (in_data_ff),
      .rsp       (eng_rsp)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_chip_select_n = out_data_ff.chip_select_n;
   assign rsp_serial_clock  = out_data_ff.serial_clock;
   assign rsp_serial_out    = out_data_ff.serial_out;
   assign rsp_rx_byte       = out_data_ff.rx_byte;
   assign rsp_rx_valid      = out_data_ff.rx_valid;
   assign rsp_rx_last       = out_data_ff.rx_last;
   assign rsp_busy_res      = out_data_ff.busy_res;
   assign rsp_status        = out_data_ff.status;

endmodule

`default_nettype wire

>>> test/tb_spi_flash_read_program_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_flash_read_program_sequencer_top: self-checking bench
// Drives tick, start and load items into the SPI flash sequencer. A scoreboard
// class tracks the pin levels and receive state of the serial engine. Each
// result is checked against the oldest prediction. Random idling runs on both
// sides, and one long output hold backs the block up. Opcodes are reprogrammed
// between phases.
// ----------------------------------------------------------------------------

module tb_spi_flash_read_program_sequencer_top;
   import sfs_pkg::*;

   localparam int RUN_LIMIT    = 2000000;
   localparam int RANDOM_ITEMS = 500;
   localparam int LONG_HOLD    = 400;
   localparam int SETTLE       = 6;
   localparam int HOLD_READ_LEN = 8;
   localparam int LONG_PROG_LEN = 16;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the serial engine state and holds due results
   // -------------------------------------------------------------------------
   class flash_pin_tracker;
      logic [7:0] wren_op, pp_op, wrdi_op, read_op;
      phase_type  phase;
      logic [3:0] half_bits;
      logic [8:0] byte_idx, xfer_len;
      logic [23:0] addr_q;
      logic [7:0] tx_shift, rx_shift;
      logic [7:0] page_mem [PAGE_BYTES];
      logic       cs_n, sck, sdo;
      rsp_type    results_due [$];
      int         mismatches;

      function new();
         wren_op    = WREN_OP_RESET;
         pp_op      = PP_OP_RESET;
         wrdi_op    = WRDI_OP_RESET;
         read_op    = READ_OP_RESET;
         phase      = PH_IDLE;
         half_bits  = '0;
         byte_idx   = '0;
         xfer_len   = '0;
         addr_q     = '0;
         tx_shift   = '0;
         rx_shift   = '0;
         cs_n       = 1'b1;
         sck        = 1'b0;
         sdo        = 1'b0;
         mismatches = 0;
         foreach (page_mem[i]) page_mem[i] = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] v);
         case (idx)
            CSR_WREN_OP: wren_op = v;
            CSR_PP_OP:   pp_op   = v;
            CSR_WRDI_OP: wrdi_op = v;
            CSR_READ_OP: read_op = v;
            default: ;
         endcase
      endfunction

      function bit busy();
         return phase != PH_IDLE;
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      // new byte in the shifter, MSB presented while the clock is low
      function void shift_load(logic [7:0] b);
         tx_shift  = b;
         half_bits = '0;
         sdo       = b[7];
      endfunction

      function logic [7:0] addr_at(logic [8:0] i);
         if (i == 0) return addr_q[23:16];
         if (i == 1) return addr_q[15:8];
         return addr_q[7:0];
      endfunction

      function logic [7:0] page_at(logic [8:0] i);
         if (i < PAGE_BYTES) return page_mem[i[7:0]];
         return '0;
      endfunction

      function void end_segment(phase_type nxt);
         cs_n      = 1'b1;
         sdo       = 1'b0;
         half_bits = '0;
         phase     = nxt;
      endfunction

      function void run_tick(logic miso, inout rsp_type r);
         bit rising;
         if (phase == PH_IDLE) return;
         if (phase == PH_GAP1) begin
            cs_n = 1'b0;
            shift_load(pp_op);
            phase = PH_PPCMD;
            return;
         end
         if (phase == PH_GAP2) begin
            cs_n = 1'b0;
            shift_load(wrdi_op);
            phase = PH_WRDI;
            return;
         end
         rising    = !half_bits[0];
         half_bits = half_bits + 4'd1;
         if (rising) begin
            sck = 1'b1;
            if (phase == PH_RDATA) rx_shift = {rx_shift[6:0], miso};
            return;
         end
         sck      = 1'b0;
         tx_shift = {tx_shift[6:0], 1'b0};
         if (half_bits != 0) begin
            sdo = (phase == PH_RDATA) ? 1'b0 : tx_shift[7];
            return;
         end
         case (phase)
            PH_WREN: end_segment(PH_GAP1);
            PH_PPCMD, PH_RCMD: begin
               byte_idx = '0;
               shift_load(addr_at(0));
               if (phase == PH_PPCMD) phase = PH_PADDR;
               else phase = PH_RADDR;
            end
            PH_PADDR, PH_RADDR: begin
               byte_idx = byte_idx + 9'd1;
               if (byte_idx < 3) begin
                  shift_load(addr_at(byte_idx));
               end else begin
                  byte_idx = '0;
                  if (xfer_len == 0) begin
                     if (phase == PH_PADDR) end_segment(PH_GAP2);
                     else end_segment(PH_IDLE);
                  end else if (phase == PH_PADDR) begin
                     shift_load(page_at(0));
                     phase = PH_PDATA;
                  end else begin
                     shift_load(8'h00);
                     rx_shift = '0;
                     phase = PH_RDATA;
                  end
               end
            end
            PH_PDATA: begin
               byte_idx = byte_idx + 9'd1;
               if (byte_idx < xfer_len) shift_load(page_at(byte_idx));
               else end_segment(PH_GAP2);
            end
            PH_RDATA: begin
               byte_idx   = byte_idx + 9'd1;
               r.rx_byte  = rx_shift;
               r.rx_valid = 1'b1;
               rx_shift   = '0;
               if (byte_idx >= xfer_len) begin
                  r.rx_last = 1'b1;
                  end_segment(PH_IDLE);
               end else begin
                  shift_load(8'h00);
               end
            end
            default: end_segment(PH_IDLE);
         endcase
      endfunction

      function void note_item(req_type q);
         rsp_type r;
         r = '0;
         case (q.cmd)
            CMD_TICK: run_tick(q.miso, r);
            CMD_LOAD: if (phase == PH_IDLE) page_mem[q.buffer_index] = q.buffer_byte;
            default: begin
               if (phase != PH_IDLE || q.length > PAGE_BYTES) begin
                  r.status = 1'b1;
               end else begin
                  addr_q   = q.address;
                  xfer_len = q.length;
                  byte_idx = '0;
                  rx_shift = '0;
                  cs_n     = 1'b0;
                  sck      = 1'b0;
                  if (q.cmd == CMD_READ) begin
                     shift_load(read_op);
                     phase = PH_RCMD;
                  end else begin
                     shift_load(wren_op);
                     phase = PH_WREN;
                  end
               end
            end
         endcase
         r.chip_select_n = cs_n;
         r.serial_clock  = sck;
         r.serial_out    = sdo;
         r.busy_res      = (phase != PH_IDLE);
         results_due.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: result with nothing due, got %h", got);
            return;
         end
         want = results_due.pop_front();
         if (got.chip_select_n !== want.chip_select_n || got.serial_clock !== want.serial_clock
             || got.serial_out !== want.serial_out || got.rx_byte !== want.rx_byte
             || got.rx_valid !== want.rx_valid || got.rx_last !== want.rx_last
             || got.busy_res !== want.busy_res || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp cs_n=%b sck=%b sdo=%b rx=%h v=%b l=%b busy=%b st=%b",
                         " | got cs_n=%b sck=%b sdo=%b rx=%h v=%b l=%b busy=%b st=%b"},
                        want.chip_select_n, want.serial_clock, want.serial_out,
                        want.rx_byte, want.rx_valid, want.rx_last, want.busy_res,
                        want.status, got.chip_select_n, got.serial_clock, got.serial_out,
                        got.rx_byte, got.rx_valid, got.rx_last, got.busy_res, got.status);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and signals
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_TICK;
   logic [23:0] req_address = '0;
   logic [8:0]  req_length = '0;
   logic [7:0]  req_buffer_index = '0;
   logic [7:0]  req_buffer_byte = '0;
   logic        req_miso = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_chip_select_n;
   logic        rsp_serial_clock;
   logic        rsp_serial_out;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_rx_valid;
   logic        rsp_rx_last;
   logic        rsp_busy_res;
   logic        rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_WREN_OP;
   logic [7:0]  csr_wdata = '0;

   spi_flash_read_program_sequencer_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_address       (req_address),
      .req_length        (req_length),
      .req_buffer_index  (req_buffer_index),
      .req_buffer_byte   (req_buffer_byte),
      .req_miso          (req_miso),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_chip_select_n (rsp_chip_select_n),
      .rsp_serial_clock  (rsp_serial_clock),
      .rsp_serial_out    (rsp_serial_out),
      .rsp_rx_byte       (rsp_rx_byte),
      .rsp_rx_valid      (rsp_rx_valid),
      .rsp_rx_last       (rsp_rx_last),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_status        (rsp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   flash_pin_tracker tracker = new();
   bit calm      = 1'b0;
   bit long_hold = 1'b0;
   int items_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   function automatic int draw_gap();
      if (calm || $urandom_range(0, 9) < 6) return 0;
      return $urandom_range(1, 18);
   endfunction

   // -------------------------------------------------------------------------
   // Result side: random stall per item, one long hold on request
   // -------------------------------------------------------------------------
   initial begin
      int      hold;
      rsp_type got;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = draw_gap();
         if (long_hold) begin
            long_hold = 1'b0;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.chip_select_n = rsp_chip_select_n;
         got.serial_clock  = rsp_serial_clock;
         got.serial_out    = rsp_serial_out;
         got.rx_byte       = rsp_rx_byte;
         got.rx_valid      = rsp_rx_valid;
         got.rx_last       = rsp_rx_last;
         got.busy_res      = rsp_busy_res;
         got.status        = rsp_status;
         tracker.check_result(got);
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   function automatic req_type rand_item(cmd_type c);
      req_type it;
      it.cmd          = c;
      it.address      = 24'($urandom);
      it.length       = 9'($urandom);
      it.buffer_index = 8'($urandom);
      it.buffer_byte  = 8'($urandom);
      it.miso         = 1'($urandom);
      return it;
   endfunction

   task automatic send_item(req_type it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= it.cmd;
      req_address      <= it.address;
      req_length       <= it.length;
      req_buffer_index <= it.buffer_index;
      req_buffer_byte  <= it.buffer_byte;
      req_miso         <= it.miso;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_item(it);
      items_sent++;
   endtask

   // wait for every due result, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [7:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      tracker.write_reg(idx, v);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_ops(logic [7:0] v);
      write_csr(CSR_WREN_OP, v);
      write_csr(CSR_PP_OP, v);
      write_csr(CSR_WRDI_OP, v);
      write_csr(CSR_READ_OP, v);
   endtask

   // miso_mode: 0 random, 1 held high, 2 held low
   task automatic tick_until_idle(int miso_mode);
      req_type it;
      while (tracker.busy()) begin
         if ($urandom_range(0, 15) == 0) begin
            // start or load while busy: rejected or ignored
            it = rand_item(cmd_type'($urandom_range(1, 3)));
         end else begin
            it = rand_item(CMD_TICK);
            if (miso_mode == 1) it.miso = 1'b1;
            else if (miso_mode == 2) it.miso = 1'b0;
         end
         send_item(it);
      end
   endtask

   task automatic run_read(int len, logic [23:0] addr, int miso_mode);
      req_type it;
      it = rand_item(CMD_READ);
      it.address = addr;
      it.length  = 9'(len);
      send_item(it);
      tick_until_idle(miso_mode);
   endtask

   // fill: 0 random bytes, 1 all ones, 2 all zeros
   task automatic run_program(int len, logic [23:0] addr, int fill);
      req_type it;
      for (int i = 0; i < len; i++) begin
         it = rand_item(CMD_LOAD);
         it.buffer_index = 8'(i);
         if (fill == 1) it.buffer_byte = 8'hff;
         else if (fill == 2) it.buffer_byte = 8'h00;
         send_item(it);
      end
      it = rand_item(CMD_PROGRAM);
      it.address = addr;
      it.length  = 9'(len);
      send_item(it);
      tick_until_idle(0);
   endtask

   task automatic send_reject(cmd_type c, logic [8:0] len);
      req_type it;
      it = rand_item(c);
      it.length = len;
      send_item(it);
   endtask

   task automatic send_load(logic [7:0] idx, logic [7:0] v);
      req_type it;
      it = rand_item(CMD_LOAD);
      it.buffer_index = idx;
      it.buffer_byte  = v;
      send_item(it);
   endtask

   // idle-time noise: ticks, loads and over-length starts
   task automatic idle_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: send_item(rand_item(CMD_TICK));
            1: send_item(rand_item(CMD_LOAD));
            2: send_reject(CMD_READ, 9'($urandom_range(257, 511)));
            default: send_reject(CMD_PROGRAM, 9'($urandom_range(257, 511)));
         endcase
      end
   endtask

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(0, 3);
      if (r < 95) return $urandom_range(4, 16);
      return $urandom_range(17, 48);
   endfunction

   function automatic logic [7:0] pick_op();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int base;
      int scenario;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: rejects, zero lengths, data extremes, opcode extremes
      send_reject(CMD_READ, 9'd511);
      send_reject(CMD_PROGRAM, 9'd257);
      run_read(0, 24'hffffff, 0);
      run_read(1, 24'h000000, 1);
      run_read(2, 24'ha5a5a5, 2);
      run_program(0, 24'h000000, 0);
      send_load(8'hff, 8'hff);
      send_load(8'h00, 8'h00);
      run_program(1, 24'hffffff, 1);
      run_program(2, 24'h5a5a5a, 2);
      drain();
      write_all_ops(8'h00);
      run_read(1, 24'h123456, 1);
      run_program(1, 24'h654321, 1);
      drain();
      write_all_ops(8'hff);
      run_read(1, 24'hfedcba, 0);
      run_program(1, 24'habcdef, 2);
      drain();

      // longer transfer each way; the read runs under a long output hold
      write_all_ops(8'($urandom));
      calm = 1'b1;
      long_hold = 1'b1;
      run_read(HOLD_READ_LEN, 24'($urandom), 0);
      calm = 1'b0;
      run_program(LONG_PROG_LEN, 24'($urandom), 0);

      base = items_sent;
      scenario = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         if (scenario % 3 == 0) begin
            drain();
            if ($urandom_range(0, 1)) write_csr(CSR_WREN_OP, pick_op());
            if ($urandom_range(0, 1)) write_csr(CSR_PP_OP, pick_op());
            if ($urandom_range(0, 1)) write_csr(CSR_WRDI_OP, pick_op());
            if ($urandom_range(0, 1)) write_csr(CSR_READ_OP, pick_op());
            calm = ($urandom_range(0, 3) == 0);
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: run_read(pick_len(), 24'($urandom), 0);
            8, 9, 10, 11, 12, 13, 14: run_program(pick_len(), 24'($urandom), 0);
            default: idle_noise();
         endcase
         scenario++;
      end

      drain();
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
rtl/sfs_pkg.sv
rtl/sfs_ram.sv
rtl/sfs_engine.sv
rtl/spi_flash_read_program_sequencer_top.sv
test/tb_spi_flash_read_program_sequencer_top.sv
